/* hw/rtl/blsp_pkg.sv */
package blsp_pkg;

    localparam int CoordBits = 6;
    localparam int MaxPoints = 64;
    localparam int PosBits = (CoordBits + 2 > 8) ? CoordBits + 2 : 8;
    localparam int ErrBits = CoordBits + 4;
    localparam int CntBits = $clog2(MaxPoints);
    localparam int StepBits = 2;
    localparam int ColourBits = 8;
    localparam int PointBits = 8;

    typedef struct packed {
        logic [CoordBits-1:0]  start_x;
        logic [CoordBits-1:0]  start_y;
        logic [CoordBits-1:0]  end_x;
        logic [CoordBits-1:0]  end_y;
        logic [ColourBits-1:0] colour;
    } t_line_cmd;

    typedef struct packed {
        logic signed [PointBits-1:0] point_x;
        logic signed [PointBits-1:0] point_y;
        logic [ColourBits-1:0]       point_colour;
        logic                        last_point;
    } t_point;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_ctl_state;

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_status;

endpackage

/* hw/rtl/blsp_ctrl.sv */
module blsp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  blsp_pkg::t_dp_status  i_status,
    output blsp_pkg::t_dp_cmd     o_dp_cmd
);

    blsp_pkg::t_ctl_state r_state;
    blsp_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd_ready = 1'b0;
        o_dp_cmd = '0;
        case (r_state)
            blsp_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state = blsp_pkg::ST_RUN;
                end
            end
            blsp_pkg::ST_RUN: begin
                if (i_status.out_free) begin
                    o_dp_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = blsp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = blsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/blsp_datapath.sv */
module blsp_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  blsp_pkg::t_line_cmd             i_cmd,
    input  logic                            i_cfg_valid,
    input  logic [blsp_pkg::StepBits-1:0]   i_cfg_data,
    input  blsp_pkg::t_dp_cmd               i_dp_cmd,
    output blsp_pkg::t_dp_status            o_status,
    output logic                            o_pt_valid,
    input  logic                            i_pt_ready,
    output blsp_pkg::t_point                o_pt
);

    localparam int Cb = blsp_pkg::CoordBits;
    localparam int Pb = blsp_pkg::PosBits;
    localparam int Eb = blsp_pkg::ErrBits;
    localparam int Nb = blsp_pkg::CntBits;

    logic [blsp_pkg::StepBits-1:0]   r_step_size;
    logic signed [Pb-1:0]            r_major_pos;
    logic signed [Pb-1:0]            r_minor_pos;
    logic signed [Pb-1:0]            r_major_end;
    logic signed [Eb-1:0]            r_error_term;
    logic signed [Eb-1:0]            r_inc_straight;
    logic signed [Eb-1:0]            r_inc_diagonal;
    logic                            r_minor_neg;
    logic                            r_y_major;
    logic [blsp_pkg::ColourBits-1:0] r_colour;
    logic [Nb-1:0]                   r_count;
    logic                            r_out_valid;
    blsp_pkg::t_point                r_out;

    logic [Cb-1:0]        w_dx;
    logic [Cb-1:0]        w_dy;
    logic                 w_y_major;
    logic [Cb-1:0]        w_major_d;
    logic [Cb-1:0]        w_minor_d;
    logic [Cb-1:0]        w_sa;
    logic [Cb-1:0]        w_sb;
    logic [Cb-1:0]        w_ea;
    logic [Cb-1:0]        w_eb;
    logic                 w_swap;
    logic [Cb-1:0]        w_start_major;
    logic [Cb-1:0]        w_start_minor;
    logic [Cb-1:0]        w_end_major;
    logic [Cb-1:0]        w_end_minor;
    logic signed [Eb-1:0] w_minor_e;
    logic signed [Eb-1:0] w_major_e;
    logic signed [Pb-1:0] w_step;
    logic signed [Pb-1:0] w_minor_step;
    logic                 w_last;
    logic                 w_out_free;
    blsp_pkg::t_point     w_point;

    always_comb begin
        w_dx = (i_cmd.end_x > i_cmd.start_x) ? i_cmd.end_x - i_cmd.start_x
                                             : i_cmd.start_x - i_cmd.end_x;
        w_dy = (i_cmd.end_y > i_cmd.start_y) ? i_cmd.end_y - i_cmd.start_y
                                             : i_cmd.start_y - i_cmd.end_y;
        w_y_major = w_dx < w_dy;
        if (w_y_major) begin
            w_major_d = w_dy;
            w_minor_d = w_dx;
            w_sa = i_cmd.start_y;
            w_sb = i_cmd.start_x;
            w_ea = i_cmd.end_y;
            w_eb = i_cmd.end_x;
        end else begin
            w_major_d = w_dx;
            w_minor_d = w_dy;
            w_sa = i_cmd.start_x;
            w_sb = i_cmd.start_y;
            w_ea = i_cmd.end_x;
            w_eb = i_cmd.end_y;
        end
        w_swap = w_sa > w_ea;
        w_start_major = w_swap ? w_ea : w_sa;
        w_start_minor = w_swap ? w_eb : w_sb;
        w_end_major = w_swap ? w_sa : w_ea;
        w_end_minor = w_swap ? w_sb : w_eb;
        w_minor_e = $signed({{(Eb - Cb){1'b0}}, w_minor_d});
        w_major_e = $signed({{(Eb - Cb){1'b0}}, w_major_d});
    end

    assign w_step = (r_step_size >= blsp_pkg::StepBits'(2)) ? Pb'(2) : Pb'(1);
    assign w_minor_step = r_minor_neg ? -w_step : w_step;
    assign w_last = !(r_major_pos < r_major_end)
                    || (r_count == Nb'(blsp_pkg::MaxPoints - 1));
    assign w_out_free = !r_out_valid || i_pt_ready;

    always_comb begin
        w_point.point_x = r_y_major ? r_minor_pos[blsp_pkg::PointBits-1:0]
                                    : r_major_pos[blsp_pkg::PointBits-1:0];
        w_point.point_y = r_y_major ? r_major_pos[blsp_pkg::PointBits-1:0]
                                    : r_minor_pos[blsp_pkg::PointBits-1:0];
        w_point.point_colour = r_colour;
        w_point.last_point = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= blsp_pkg::StepBits'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step_size <= i_cfg_data;
            end
            if (i_dp_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pt_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_out <= w_point;
        end
        if (i_dp_cmd.load) begin
            r_major_pos <= $signed({{(Pb - Cb){1'b0}}, w_start_major});
            r_minor_pos <= $signed({{(Pb - Cb){1'b0}}, w_start_minor});
            r_major_end <= $signed({{(Pb - Cb){1'b0}}, w_end_major});
            r_error_term <= (w_minor_e <<< 1) - w_major_e;
            r_inc_straight <= w_minor_e <<< 1;
            r_inc_diagonal <= (w_minor_e - w_major_e) <<< 1;
            r_minor_neg <= w_start_minor > w_end_minor;
            r_y_major <= w_y_major;
            r_colour <= i_cmd.colour;
            r_count <= '0;
        end else if (i_dp_cmd.emit && !w_last) begin
            r_major_pos <= r_major_pos + w_step;
            if (r_error_term < 0) begin
                r_error_term <= r_error_term + r_inc_straight;
            end else begin
                r_minor_pos <= r_minor_pos + w_minor_step;
                r_error_term <= r_error_term + r_inc_diagonal;
            end
            r_count <= r_count + Nb'(1);
        end
    end

    assign o_status.out_free = w_out_free;
    assign o_status.last = w_last;
    assign o_pt_valid = r_out_valid;
    assign o_pt = r_out;

endmodule

/* hw/rtl/bresenham_line_stepper.sv */
// Line stepper: a command beat carries two endpoints and a color, and the block
// returns one point beat per plotted pixel, walking the major axis from its lower
// end by the configured step of 1 or 2, the final beat flagged by last_point.
// A command is accepted and set up in the idle state, and a line holds at most 64
// points; in the run state, while the point port is not stalled, the controller
// issues one point per cycle from the datapath registers into the
// output register. The next command is taken while the final point still waits
// in that register. The step register may be written at any time the block is idle.
module bresenham_line_stepper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  blsp_pkg::t_line_cmd           i_cmd,
    output logic                          o_pt_valid,
    input  logic                          i_pt_ready,
    output blsp_pkg::t_point              o_pt,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [blsp_pkg::StepBits-1:0] i_cfg_data
);

    blsp_pkg::t_dp_cmd    w_dp_cmd;
    blsp_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    blsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_status    (w_status),
        .o_dp_cmd    (w_dp_cmd)
    );

    blsp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_dp_cmd    (w_dp_cmd),
        .o_status    (w_status),
        .o_pt_valid  (o_pt_valid),
        .i_pt_ready  (i_pt_ready),
        .o_pt        (o_pt)
    );

endmodule

/* hw/rtl/blsp_checker.sv */
module blsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          o_cmd_ready,
    input logic                          o_pt_valid,
    input logic                          i_pt_ready,
    input blsp_pkg::t_point              o_pt
);

    // A stalled point beat keeps its contents.
    a_pt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt_valid && !i_pt_ready |=> o_pt_valid && $stable(o_pt))
        else $error("point beat changed while stalled");

    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && o_cmd_ready |=> !o_cmd_ready)
        else $error("command port ready right after a command beat");

    a_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt_valid && !o_pt.last_point |-> !o_cmd_ready)
        else $error("command port ready in the middle of a line");

    a_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt_valid && i_pt_ready && !o_pt.last_point |=>
        !o_pt_valid || (o_pt.point_colour == $past(o_pt.point_colour)))
        else $error("color changed within a line");

endmodule

bind bresenham_line_stepper blsp_checker u_blsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd_valid),
    .o_cmd_ready (o_cmd_ready),
    .o_pt_valid  (o_pt_valid),
    .i_pt_ready  (i_pt_ready),
    .o_pt        (o_pt)
);

/* verif/tb_bresenham_line_stepper.sv */
module tb_bresenham_line_stepper;

    localparam logic [blsp_pkg::StepBits-1:0] StepRegZero = 2'd0;
    localparam logic [blsp_pkg::StepBits-1:0] StepRegOne = 2'd1;
    localparam logic [blsp_pkg::StepBits-1:0] StepRegTwo = 2'd2;
    localparam logic [blsp_pkg::StepBits-1:0] StepRegThree = 2'd3;
    localparam int CoordMax = (1 << blsp_pkg::CoordBits) - 1;
    localparam int NumRows = 16;
    localparam int LinesPerPhase = 45;
    localparam int HoldCycles = 400;

    typedef struct packed {
        blsp_pkg::t_line_cmd cmd;
        logic                typed;
        blsp_pkg::t_point    pt;
    } t_line_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cmd_valid = 1'b0;
    logic                          o_cmd_ready;
    blsp_pkg::t_line_cmd           i_cmd = '0;
    logic                          o_pt_valid;
    logic                          i_pt_ready = 1'b0;
    blsp_pkg::t_point              o_pt;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [blsp_pkg::StepBits-1:0] i_cfg_data = '0;

    blsp_pkg::t_point              expected_points[$];
    t_line_row                     line_rows[NumRows];
    logic [blsp_pkg::StepBits-1:0] step_reg = StepRegOne;
    logic [blsp_pkg::StepBits-1:0] step_plan[6];
    int                            tx_idle_pct = 0;
    int                            rx_idle_pct = 0;
    event                          stall_start;
    logic                          hold_active = 1'b0;
    int                            errors = 0;
    int                            lines_sent = 0;
    int                            single_lines = 0;
    int                            steep_lines = 0;
    int                            points_seen = 0;

    bresenham_line_stepper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_pt_valid  (o_pt_valid),
        .i_pt_ready  (i_pt_ready),
        .o_pt        (o_pt),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("bresenham_line_stepper: mismatch");
        $finish;
    end

    function automatic blsp_pkg::t_line_cmd mk_line(input int sx, input int sy, input int ex,
                                                    input int ey, input int col);
        blsp_pkg::t_line_cmd c;
        c.start_x = sx[blsp_pkg::CoordBits-1:0];
        c.start_y = sy[blsp_pkg::CoordBits-1:0];
        c.end_x = ex[blsp_pkg::CoordBits-1:0];
        c.end_y = ey[blsp_pkg::CoordBits-1:0];
        c.colour = col[blsp_pkg::ColourBits-1:0];
        return c;
    endfunction

    function automatic blsp_pkg::t_point mk_point(input int x, input int y, input int col);
        blsp_pkg::t_point p;
        p.point_x = x[blsp_pkg::PointBits-1:0];
        p.point_y = y[blsp_pkg::PointBits-1:0];
        p.point_colour = col[blsp_pkg::ColourBits-1:0];
        p.last_point = 1'b1;
        return p;
    endfunction

    // Walks the line exactly as the block should and queues every point it plots.
    function automatic void trace_line(input blsp_pkg::t_line_cmd c);
        int x1, y1, x2, y2, dx, dy, adv, maj_d, min_d;
        int maj, mnr, maj_stop, mnr_stop, err, dir, count, tmp;
        bit steep;
        blsp_pkg::t_point p;
        x1 = c.start_x;
        y1 = c.start_y;
        x2 = c.end_x;
        y2 = c.end_y;
        adv = (step_reg >= StepRegTwo) ? 2 : 1;
        dx = (x2 > x1) ? x2 - x1 : x1 - x2;
        dy = (y2 > y1) ? y2 - y1 : y1 - y2;
        steep = dx < dy;
        if (steep) begin
            maj_d = dy; min_d = dx; maj = y1; mnr = x1; maj_stop = y2; mnr_stop = x2;
            steep_lines++;
        end else begin
            maj_d = dx; min_d = dy; maj = x1; mnr = y1; maj_stop = x2; mnr_stop = y2;
        end
        if (maj > maj_stop) begin
            tmp = maj; maj = maj_stop; maj_stop = tmp;
            tmp = mnr; mnr = mnr_stop; mnr_stop = tmp;
        end
        err = 2 * min_d - maj_d;
        dir = (mnr > mnr_stop) ? -adv : adv;
        count = 0;
        forever begin
            p.point_x = steep ? mnr[blsp_pkg::PointBits-1:0] : maj[blsp_pkg::PointBits-1:0];
            p.point_y = steep ? maj[blsp_pkg::PointBits-1:0] : mnr[blsp_pkg::PointBits-1:0];
            p.point_colour = c.colour;
            p.last_point = !(maj < maj_stop && count + 1 < blsp_pkg::MaxPoints);
            expected_points.push_back(p);
            count++;
            if (p.last_point) break;
            maj += adv;
            if (err < 0) begin
                err += 2 * min_d;
            end else begin
                mnr += dir;
                err += 2 * (min_d - maj_d);
            end
        end
        if (count == 1) single_lines++;
    endfunction

    function automatic blsp_pkg::t_line_cmd random_line();
        blsp_pkg::t_line_cmd c;
        c = mk_line($urandom_range(CoordMax), $urandom_range(CoordMax),
                    $urandom_range(CoordMax), $urandom_range(CoordMax), $urandom_range(255));
        case ($urandom_range(9))
            0: begin
                c.end_x = c.start_x;
                c.end_y = c.start_y;
            end
            1: c.end_y = c.start_y;
            2: c.end_x = c.start_x;
            3: c = mk_line($urandom_range(1) * CoordMax, $urandom_range(1) * CoordMax,
                           $urandom_range(1) * CoordMax, $urandom_range(1) * CoordMax,
                           $urandom_range(255));
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_line(input blsp_pkg::t_line_cmd c);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_cmd_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_cmd_valid <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (!o_cmd_ready);
        lines_sent++;
    endtask

    task automatic write_step(input logic [blsp_pkg::StepBits-1:0] v);
        i_cmd_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        step_reg = v;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // The long hold on the point port runs on its own cycle count.
    always begin : rx_hold
        @(stall_start);
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin : pt_sink
        blsp_pkg::t_point want;
        if (i_rst_n && o_pt_valid && i_pt_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                errors++;
                $display("%0t: point beat x=%0d y=%0d with nothing expected, got extra beat",
                         $time, o_pt.point_x, o_pt.point_y);
            end else begin
                want = expected_points.pop_front();
                check_field("point_x", want.point_x, o_pt.point_x);
                check_field("point_y", want.point_y, o_pt.point_y);
                check_field("point_colour", want.point_colour, o_pt.point_colour);
                check_field("last_point", want.last_point, o_pt.last_point);
            end
        end
        if (hold_active) begin
            i_pt_ready <= 1'b0;
        end else begin
            i_pt_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        line_rows = '{
            '{mk_line(0, 0, 0, 0, 8'h00), 1'b1, mk_point(0, 0, 8'h00)},
            '{mk_line(63, 63, 63, 63, 8'hFF), 1'b1, mk_point(63, 63, 8'hFF)},
            '{mk_line(0, 63, 0, 63, 8'h5A), 1'b1, mk_point(0, 63, 8'h5A)},
            '{mk_line(63, 0, 63, 0, 8'hA5), 1'b1, mk_point(63, 0, 8'hA5)},
            '{mk_line(0, 0, 63, 63, 8'h81), 1'b0, '0},
            '{mk_line(63, 0, 0, 63, 8'h7E), 1'b0, '0},
            '{mk_line(0, 0, 63, 0, 8'h0F), 1'b0, '0},
            '{mk_line(0, 0, 0, 63, 8'hF0), 1'b0, '0},
            '{mk_line(63, 0, 0, 0, 8'h33), 1'b0, '0},
            '{mk_line(0, 63, 0, 0, 8'hCC), 1'b0, '0},
            '{mk_line(10, 20, 50, 30, 8'h12), 1'b0, '0},
            '{mk_line(50, 30, 10, 20, 8'h34), 1'b0, '0},
            '{mk_line(5, 5, 10, 60, 8'h56), 1'b0, '0},
            '{mk_line(10, 60, 5, 5, 8'h78), 1'b0, '0},
            '{mk_line(30, 30, 31, 30, 8'h9A), 1'b0, '0},
            '{mk_line(1, 2, 2, 1, 8'hBC), 1'b0, '0}
        };
        step_plan = '{StepRegTwo, StepRegZero, StepRegThree, StepRegOne, StepRegTwo,
                      StepRegThree};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (line_rows[i]) begin
            send_line(line_rows[i].cmd);
            if (line_rows[i].typed) begin
                expected_points.push_back(line_rows[i].pt);
                single_lines++;
            end else begin
                trace_line(line_rows[i].cmd);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            write_step(step_plan[phase]);
            case (phase / 2)
                0: begin tx_idle_pct = 20; rx_idle_pct = 74; end
                1: begin tx_idle_pct = 74; rx_idle_pct = 20; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (phase == 4) -> stall_start;
            for (int n = 0; n < LinesPerPhase; n++) begin : random_lines
                blsp_pkg::t_line_cmd c;
                c = random_line();
                send_line(c);
                trace_line(c);
            end
        end

        i_cmd_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d line commands (%0d single points, %0d steep), checked %0d beats.",
                 lines_sent, single_lines, steep_lines, points_seen);
        $display("The step register took every value from 0 to 3, and the point port was held");
        $display("off for %0d cycles once while commands kept coming.", HoldCycles);
        if (errors == 0) begin
            $display("bresenham_line_stepper: match");
        end else begin
            $display("bresenham_line_stepper: mismatch");
        end
        $finish;
    end

endmodule
